>>> hw/rtl/svd_pkg.sv
`timescale 1ns / 1ps

package svd_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 7;
  localparam int unsigned LeftW  = 4;
  localparam int unsigned PosW   = 3;

endpackage

>>> hw/rtl/signed_varint_decoder_core.sv
`timescale 1ns / 1ps

// Decoder for a byte stream of length-prefixed sign-magnitude integers.
// Input channel: one byte per transfer (in_byte_in) with in_end_of_message
// marking the last byte of a message. Each integer is a tag byte (bit 0 set
// for non-negative, bits 7..1 the byte count) followed by the magnitude
// bytes, least significant first.
// Result channel: out_value with out_status (ok, count too large, message
// truncated). A result follows the tag of a zero or oversized count, the
// last magnitude byte, or a byte that ends a message early.
// The result is formed in the single accumulate-and-negate stage from the
// byte that completes it and is registered into the output register.
// Throughput: one byte per cycle while in_stall is low.
// When the receiver stalls, one further result is held in a skid register
// and in_stall rises in the next cycle until the output drains.
// Reset (synchronous, rst_n low) returns the decoder to awaiting a tag and
// empties the output stage.
module signed_varint_decoder_core #(
  parameter int unsigned MAX_LEN = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte_in,
  input  logic               in_end_of_message,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_value,
  output logic [1:0]         out_status
);
  import svd_pkg::*;

  logic [LeftW-1:0]  bytes_left_r, bytes_left_nxt;
  logic [PosW-1:0]   byte_pos_r, byte_pos_nxt;
  logic              is_pos_r, is_pos_nxt;
  logic [ValueW-1:0] mag_r, mag_nxt;

  logic              out_valid_r;
  logic [ValueW-1:0] out_value_r;
  status_t           out_status_r;
  logic              skid_valid_r;
  logic [ValueW-1:0] skid_value_r;
  status_t           skid_status_r;

  logic              in_xfer;
  logic              out_xfer;
  logic [CountW-1:0] count;
  logic [ValueW-1:0] mag_acc;
  logic              res_valid;
  logic [ValueW-1:0] res_value;
  status_t           res_status;

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;
  assign out_xfer = out_valid_r && !out_stall;
  assign count    = in_byte_in[7:1];
  assign mag_acc  = mag_r | (ValueW'(in_byte_in) << {byte_pos_r, 3'b000});

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    byte_pos_nxt   = byte_pos_r;
    is_pos_nxt     = is_pos_r;
    mag_nxt        = mag_r;
    res_valid      = 1'b0;
    res_value      = '0;
    res_status     = ST_OK;
    if (in_xfer) begin
      if (bytes_left_r == '0) begin
        if (count == '0) begin
          res_valid = 1'b1;
        end else if (count > CountW'(MAX_LEN)) begin
          res_valid  = 1'b1;
          res_status = ST_TOO_LONG;
        end else if (in_end_of_message) begin
          res_valid  = 1'b1;
          res_status = ST_TRUNCATED;
        end else begin
          bytes_left_nxt = count[LeftW-1:0];
          byte_pos_nxt   = '0;
          is_pos_nxt     = in_byte_in[0];
          mag_nxt        = '0;
        end
      end else if (bytes_left_r == LeftW'(1)) begin
        res_valid      = 1'b1;
        res_value      = is_pos_r ? mag_acc : (~mag_acc + ValueW'(1));
        bytes_left_nxt = '0;
        byte_pos_nxt   = '0;
        is_pos_nxt     = 1'b0;
        mag_nxt        = '0;
      end else if (in_end_of_message) begin
        res_valid      = 1'b1;
        res_status     = ST_TRUNCATED;
        bytes_left_nxt = '0;
        byte_pos_nxt   = '0;
        is_pos_nxt     = 1'b0;
        mag_nxt        = '0;
      end else begin
        bytes_left_nxt = bytes_left_r - LeftW'(1);
        byte_pos_nxt   = byte_pos_r + PosW'(1);
        mag_nxt        = mag_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      byte_pos_r   <= '0;
      is_pos_r     <= 1'b0;
      mag_r        <= '0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      byte_pos_r   <= byte_pos_nxt;
      is_pos_r     <= is_pos_nxt;
      mag_r        <= mag_nxt;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_xfer) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= res_valid;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_xfer) begin
      if (skid_valid_r) begin
        out_value_r   <= skid_value_r;
        out_status_r  <= skid_status_r;
        skid_value_r  <= res_value;
        skid_status_r <= res_status;
      end else begin
        out_value_r   <= res_value;
        out_status_r  <= res_status;
      end
    end else if (res_valid) begin
      skid_value_r  <= res_value;
      skid_status_r <= res_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r <= LeftW'(MAX_LEN))
    else $error("byte count beyond the maximum length");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_left_r == '0) |-> (byte_pos_r == '0 && mag_r == '0))
    else $error("accumulator not cleared while awaiting a tag");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && skid_valid_r) |-> !res_valid)
    else $error("result produced with both output entries full");

endmodule
